// ----- sv/slcfr_pkg.sv -----
`default_nettype none

package slcfr_pkg;

    // frame buffer size and derived widths
    localparam int BUFFER_DEPTH = 64;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int CMP_W        = (CNT_W + 1 > BYTE_W + 1) ? CNT_W + 1 : BYTE_W + 1;

    // length byte position and minimum count before the length check
    localparam int LEN_POS       = 3;
    localparam int MIN_CHECK_CNT = 4;

    // configuration register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAIL_FIRST_RST  = 8'h0D;
    localparam logic [BYTE_W-1:0] TRAIL_SECOND_RST = 8'h0A;

    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SYNC_FIRST   = 2'd0,
        CFG_SYNC_SECOND  = 2'd1,
        CFG_TRAIL_FIRST  = 2'd2,
        CFG_TRAIL_SECOND = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] trail_first;
        logic [BYTE_W-1:0] trail_second;
    } t_cfg;

    typedef struct packed {
        logic              held;
        logic              frame_abort;
        logic              frame_done;
        logic [BYTE_W-1:0] store_byte;
        logic [IDX_W-1:0]  store_index;
        logic              store_valid;
    } t_result;

    localparam int RES_W      = $bits(t_result);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- sv/slcfr_cfg.sv -----
`default_nettype none

module slcfr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [slcfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [slcfr_pkg::BYTE_W-1:0]     i_cfg_wdata,
    output slcfr_pkg::t_cfg                       o_cfg
);

    slcfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first   <= slcfr_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second  <= slcfr_pkg::SYNC_SECOND_RST;
            r_cfg.trail_first  <= slcfr_pkg::TRAIL_FIRST_RST;
            r_cfg.trail_second <= slcfr_pkg::TRAIL_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (slcfr_pkg::t_cfg_idx'(i_cfg_addr))
                slcfr_pkg::CFG_SYNC_FIRST:   r_cfg.sync_first   <= i_cfg_wdata;
                slcfr_pkg::CFG_SYNC_SECOND:  r_cfg.sync_second  <= i_cfg_wdata;
                slcfr_pkg::CFG_TRAIL_FIRST:  r_cfg.trail_first  <= i_cfg_wdata;
                slcfr_pkg::CFG_TRAIL_SECOND: r_cfg.trail_second <= i_cfg_wdata;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/slcfr_step.sv -----
`default_nettype none

module slcfr_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire slcfr_pkg::t_cfg             i_cfg,
    input  wire logic                        i_accept,
    input  wire logic                        i_mode,
    input  wire logic [slcfr_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_advance,
    output logic                             o_in_valid,
    output slcfr_pkg::t_result               o_res
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC1 = 2'd1,
        PH_BODY  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    localparam int CNT_W = slcfr_pkg::CNT_W;
    localparam int CMP_W = slcfr_pkg::CMP_W;

    // input register
    logic                        r_in_valid;
    logic                        r_in_mode;
    logic [slcfr_pkg::BYTE_W-1:0] r_in_byte;

    // frame state
    t_phase                       r_phase, n_phase;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [slcfr_pkg::BYTE_W-1:0] r_len, n_len;
    logic                         r_held, n_held;

    logic [CNT_W-1:0]  cnt_inc;
    logic [CMP_W-1:0]  cnt_next_cmp;
    slcfr_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_accept) begin
            r_in_valid <= 1'b1;
        end else if (i_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_byte;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_len        = r_len;
        n_held       = r_held;
        res          = '0;
        cnt_inc      = r_count + CNT_W'(1);
        // this byte's position plus two, compared against the length byte
        cnt_next_cmp = CMP_W'(r_count) + CMP_W'(2);

        if (r_in_mode) begin
            n_held = 1'b0;
        end else if (!r_held) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_in_byte == i_cfg.sync_first) begin
                        res.store_valid = 1'b1;
                        res.store_byte  = r_in_byte;
                        n_count         = CNT_W'(1);
                        n_phase         = PH_SYNC1;
                    end
                end
                PH_SYNC1: begin
                    priority if (r_in_byte == i_cfg.sync_second) begin
                        res.store_valid = 1'b1;
                        res.store_index = slcfr_pkg::IDX_W'(1);
                        res.store_byte  = r_in_byte;
                        n_count         = CNT_W'(2);
                        n_phase         = PH_BODY;
                    end else if (r_in_byte == i_cfg.sync_first) begin
                        // repeated first sync restarts at position zero
                        res.store_valid = 1'b1;
                        res.store_byte  = r_in_byte;
                        n_count         = CNT_W'(1);
                    end else begin
                        res.frame_abort = 1'b1;
                        n_count         = '0;
                        n_phase         = PH_HUNT;
                    end
                end
                PH_BODY, PH_TRAIL: begin
                    if (r_count >= CNT_W'(slcfr_pkg::BUFFER_DEPTH)) begin
                        // overrun
                        res.frame_abort = 1'b1;
                        n_count         = '0;
                        n_phase         = PH_HUNT;
                    end else begin
                        res.store_valid = 1'b1;
                        res.store_index = r_count[slcfr_pkg::IDX_W-1:0];
                        res.store_byte  = r_in_byte;
                        if (r_count == CNT_W'(slcfr_pkg::LEN_POS)) begin
                            n_len = r_in_byte;
                        end
                        n_count = cnt_inc;
                        if (r_phase == PH_BODY) begin
                            if (cnt_inc >= CNT_W'(slcfr_pkg::MIN_CHECK_CNT) &&
                                cnt_next_cmp == CMP_W'(n_len)) begin
                                if (r_in_byte == i_cfg.trail_first) begin
                                    n_phase = PH_TRAIL;
                                end else begin
                                    res.frame_abort = 1'b1;
                                    n_count         = '0;
                                    n_phase         = PH_HUNT;
                                end
                            end
                        end else begin
                            if (r_in_byte == i_cfg.trail_second) begin
                                res.frame_done = 1'b1;
                                n_held         = 1'b1;
                            end else begin
                                res.frame_abort = 1'b1;
                            end
                            n_count = '0;
                            n_phase = PH_HUNT;
                        end
                    end
                end
            endcase
        end
        res.held = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_len   <= '0;
            r_held  <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_held  <= n_held;
        end
    end

    assign o_in_valid = r_in_valid;
    assign o_res      = res;

`ifndef SYNTHESIS
    a_held_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_phase == PH_HUNT))
        else $error("held frame while not hunting");

    a_hunt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_count == '0))
        else $error("stored count not cleared while hunting");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(slcfr_pkg::BUFFER_DEPTH))
        else $error("stored count beyond buffer depth");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.frame_done) |=> r_held)
        else $error("completed frame not held");
`endif

endmodule

`default_nettype wire

// ----- sv/slcfr_out.sv -----
`default_nettype none

module slcfr_out (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire slcfr_pkg::t_result i_res,
    input  wire logic         i_ready,
    output logic              o_can_take,
    output logic              o_valid,
    output slcfr_pkg::t_result o_res
);

    logic               r_valid;
    slcfr_pkg::t_result r_res;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ----- sv/sync_length_crlf_frame_receiver.sv -----
// path: an accepted byte sits in the input register, and its result moves into the
//   output register once that one has room and transfers from there
// throughput: one byte per cycle; the result register frees itself in the same cycle
//   that its transfer is taken, so stalls only come from the downstream side
// reset: synchronous active-low i_rst_n clears the handshake, the frame state and
//   loads the sync and trailer registers with 0x55, 0xaa, 0x0d, 0x0a
`default_nettype none

module sync_length_crlf_frame_receiver (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [slcfr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [slcfr_pkg::BYTE_W-1:0]        i_cfg_wdata,

    // received bytes
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [slcfr_pkg::BYTE_W-1:0]        s_axis_tdata,  // rx_byte
    input  wire logic                                s_axis_tuser,  // mode

    // per-byte results
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // store_valid, store_index, store_byte, frame_done, frame_abort, held, zero pad
    output logic [slcfr_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    slcfr_pkg::t_cfg    cfg;
    slcfr_pkg::t_result step_res;
    slcfr_pkg::t_result out_res;

    logic in_accept;
    logic in_valid;
    logic out_can_take;
    logic advance;

    // input register moves into the result register whenever that one has room
    assign advance       = in_valid && out_can_take;
    assign s_axis_tready = !in_valid || out_can_take;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    slcfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // frame state and per-byte decision
    slcfr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (in_accept),
        .i_mode     (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_advance  (advance),
        .o_in_valid (in_valid),
        .o_res      (step_res)
    );

    // result register
    slcfr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (step_res),
        .i_ready    (m_axis_tready),
        .o_can_take (out_can_take),
        .o_valid    (m_axis_tvalid),
        .o_res      (out_res)
    );

    // struct is declared high field first, so its packed bits already put
    // store_valid at bit zero
    assign m_axis_tdata = slcfr_pkg::OUT_DATA_W'(out_res);

endmodule

`default_nettype wire

// ----- verif/slcfr_result_checker.sv -----
// watches both stream channels and the register port, predicts each result
// and compares it field by field against what the block sends
module slcfr_result_checker
    import slcfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_in_tvalid,
    input  wire logic                  i_in_tready,
    input  wire logic [BYTE_W-1:0]     i_in_tdata,   // rx_byte
    input  wire logic                  i_in_tuser,   // mode
    input  wire logic                  i_out_tvalid,
    input  wire logic                  i_out_tready,
    // store_valid, store_index, store_byte, frame_done, frame_abort, held, zero pad
    input  wire logic [OUT_DATA_W-1:0] i_out_tdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_done_count,
    output int                         o_abort_count
);

    typedef enum logic [1:0] {
        HUNT_SYNC,
        GOT_SYNC,
        IN_BODY,
        AWAIT_TRAIL
    } t_rx_phase;

    t_cfg              cfg;
    t_rx_phase         rx_phase;
    logic [6:0]        stored_cnt;
    logic [BYTE_W-1:0] frame_len;
    logic              frame_held;
    t_result           expected_q[$];
    int                mismatches;
    int                done_cnt;
    int                abort_cnt;

    function automatic string fmt_result(input t_result r);
        return $sformatf("valid=%0d idx=%0d byte=0x%02h done=%0d abort=%0d held=%0d",
                         r.store_valid, r.store_index, r.store_byte,
                         r.frame_done, r.frame_abort, r.held);
    endfunction

    task automatic restart_hunt();
        rx_phase   = HUNT_SYNC;
        stored_cnt = '0;
    endtask

    // one received byte or release in, one result out
    task automatic deframe_byte(input logic mode, input logic [BYTE_W-1:0] b,
                                output t_result r);
        r = '0;
        if (mode) begin
            frame_held = 1'b0;
        end else if (!frame_held) begin
            case (rx_phase)
                HUNT_SYNC: begin
                    if (b == cfg.sync_first) begin
                        r.store_valid = 1'b1;
                        r.store_byte  = b;
                        stored_cnt    = 7'd1;
                        rx_phase      = GOT_SYNC;
                    end
                end
                GOT_SYNC: begin
                    if (b == cfg.sync_second) begin
                        r.store_valid = 1'b1;
                        r.store_index = 6'd1;
                        r.store_byte  = b;
                        stored_cnt    = 7'd2;
                        rx_phase      = IN_BODY;
                    end else if (b == cfg.sync_first) begin
                        r.store_valid = 1'b1;
                        r.store_byte  = b;
                        stored_cnt    = 7'd1;
                    end else begin
                        r.frame_abort = 1'b1;
                        restart_hunt();
                    end
                end
                default: begin
                    if (stored_cnt >= BUFFER_DEPTH) begin
                        // buffer overrun, byte not stored
                        r.frame_abort = 1'b1;
                        restart_hunt();
                    end else begin
                        r.store_valid = 1'b1;
                        r.store_index = stored_cnt[IDX_W-1:0];
                        r.store_byte  = b;
                        if (stored_cnt == LEN_POS)
                            frame_len = b;
                        stored_cnt = stored_cnt + 7'd1;
                        if (rx_phase == IN_BODY) begin
                            if (stored_cnt >= MIN_CHECK_CNT &&
                                int'(stored_cnt) + 1 == int'(frame_len)) begin
                                if (b == cfg.trail_first) begin
                                    rx_phase = AWAIT_TRAIL;
                                end else begin
                                    r.frame_abort = 1'b1;
                                    restart_hunt();
                                end
                            end
                        end else begin
                            if (b == cfg.trail_second) begin
                                r.frame_done = 1'b1;
                                frame_held   = 1'b1;
                            end else begin
                                r.frame_abort = 1'b1;
                            end
                            restart_hunt();
                        end
                    end
                end
            endcase
        end
        r.held = frame_held;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        t_result got_r;
        if (!i_rst_n) begin
            cfg.sync_first   = SYNC_FIRST_RST;
            cfg.sync_second  = SYNC_SECOND_RST;
            cfg.trail_first  = TRAIL_FIRST_RST;
            cfg.trail_second = TRAIL_SECOND_RST;
            frame_len        = '0;
            frame_held       = 1'b0;
            restart_hunt();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SYNC_FIRST:   cfg.sync_first   = i_cfg_wdata;
                    CFG_SYNC_SECOND:  cfg.sync_second  = i_cfg_wdata;
                    CFG_TRAIL_FIRST:  cfg.trail_first  = i_cfg_wdata;
                    CFG_TRAIL_SECOND: cfg.trail_second = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_tvalid && i_out_tready) begin
                got_r = t_result'(i_out_tdata[RES_W-1:0]);
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result with nothing pending: %s",
                                 fmt_result(got_r));
                    mismatches++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.store_valid !== exp_r.store_valid ||
                        got_r.store_index !== exp_r.store_index ||
                        got_r.store_byte  !== exp_r.store_byte  ||
                        got_r.frame_done  !== exp_r.frame_done  ||
                        got_r.frame_abort !== exp_r.frame_abort ||
                        got_r.held        !== exp_r.held) begin
                        if (mismatches < 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_result(exp_r));
                            $display("  actual   %s", fmt_result(got_r));
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                deframe_byte(i_in_tuser, i_in_tdata, exp_r);
                expected_q.push_back(exp_r);
                if (exp_r.frame_done)
                    done_cnt++;
                if (exp_r.frame_abort)
                    abort_cnt++;
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= expected_q.size();
        o_done_count  <= done_cnt;
        o_abort_count <= abort_cnt;
    end

endmodule

// ----- verif/sync_length_crlf_frame_receiver_tb.sv -----
// top of the deframer bench: drives bytes, releases and register writes,
// toggles backpressure, and gives the verdict from the checker's counts
module sync_length_crlf_frame_receiver_tb;

    import slcfr_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT  = 4000;
    localparam int NUM_PHASES  = 5;
    localparam int PHASE_BYTES = 80;

    // what kind of damage a generated frame carries
    typedef enum int {
        FRAME_OK,
        BAD_TRAIL_FIRST,
        BAD_TRAIL_SECOND
    } t_frame_fault;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [BYTE_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tready = 1'b0;
    wire logic             s_axis_tready;
    wire logic             m_axis_tvalid;
    wire logic [OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   done_count;
    int   abort_count;

    // knobs for the current phase
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   bytes_sent     = 0;
    int   idle_cycles    = 0;
    t_cfg cur_cfg;

    sync_length_crlf_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    slcfr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_done_count  (done_count),
        .o_abort_count (abort_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hang detector: any transfer on either channel resets the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending);
            $display("sync_length_crlf_frame_receiver_tb failed");
            $finish;
        end
    end

    // any byte except v
    function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] v);
        return v + BYTE_W'($urandom_range(1, 255));
    endfunction

    // one input transfer; tready is looked at on the falling edge so the
    // decision never races the rising edge that takes the transfer
    task automatic send_item(input logic mode, input logic [BYTE_W-1:0] b);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= mode;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        bytes_sent++;
    endtask

    // hold off input until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        // then wait on so nothing is still in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        write_reg(CFG_SYNC_FIRST,   c.sync_first);
        write_reg(CFG_SYNC_SECOND,  c.sync_second);
        write_reg(CFG_TRAIL_FIRST,  c.trail_first);
        write_reg(CFG_TRAIL_SECOND, c.trail_second);
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // header, length byte, random body and trailer; n_bytes may run past len
    // so that short or absurd lengths reach the overrun abort
    task automatic send_frame(input int len, input int n_bytes, input t_frame_fault fault);
        int                pos;
        logic [BYTE_W-1:0] b;
        for (pos = 0; pos < n_bytes; pos++) begin
            if (pos == 0)
                b = cur_cfg.sync_first;
            else if (pos == 1)
                b = cur_cfg.sync_second;
            else if (pos == LEN_POS)
                b = BYTE_W'(len);
            else if (pos == len - 2)
                b = (fault == BAD_TRAIL_FIRST) ? other_than(cur_cfg.trail_first)
                                               : cur_cfg.trail_first;
            else if (pos == len - 1)
                b = (fault == BAD_TRAIL_SECOND) ? other_than(cur_cfg.trail_second)
                                                : cur_cfg.trail_second;
            else
                b = BYTE_W'($urandom_range(255));
            // a stray release in the middle of a frame must not disturb it
            if (pos > 0 && $urandom_range(99) < 3)
                send_item(1'b1, BYTE_W'($urandom_range(255)));
            send_item(1'b0, b);
        end
    endtask

    // one random sequence: mostly well-formed frames, some broken ones, noise
    task automatic run_sequence();
        int                pick;
        int                len;
        int                lo;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(99);
        // a length of five only works when the length byte is the first trailer
        lo   = (cur_cfg.trail_first == 8'd5) ? 5 : 6;
        if (pick < 50) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, BUFFER_DEPTH)
                                           : $urandom_range(lo, 16);
            send_frame(len, len, FRAME_OK);
            // bytes while the frame is held get dropped
            repeat ($urandom_range(0, 3)) send_item(1'b0, BYTE_W'($urandom_range(255)));
            send_item(1'b1, BYTE_W'($urandom_range(255)));
        end else if (pick < 60) begin
            len = $urandom_range(6, 20);
            send_frame(len, len, BAD_TRAIL_FIRST);
        end else if (pick < 70) begin
            len = $urandom_range(6, 20);
            send_frame(len, len, BAD_TRAIL_SECOND);
        end else if (pick < 74) begin
            // too short to ever match, runs into the overrun
            send_frame($urandom_range(0, 4), BUFFER_DEPTH + 2, FRAME_OK);
        end else if (pick < 78) begin
            // longer than the buffer
            send_frame($urandom_range(BUFFER_DEPTH + 1, 255), BUFFER_DEPTH + 2, FRAME_OK);
        end else if (pick < 86) begin
            // first sync, maybe repeated, then a byte that breaks the header
            send_item(1'b0, cur_cfg.sync_first);
            if ($urandom_range(1))
                send_item(1'b0, cur_cfg.sync_first);
            do b = BYTE_W'($urandom_range(255));
            while (b == cur_cfg.sync_first || b == cur_cfg.sync_second);
            send_item(1'b0, b);
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 6))
                send_item($urandom_range(9) == 0, BYTE_W'($urandom_range(255)));
        end else begin
            drain_results();
        end
    endtask

    initial begin : stimulus
        t_cfg phase_cfg[NUM_PHASES];
        int   phase_send_idle[NUM_PHASES];
        int   phase_recv_stall[NUM_PHASES];
        int   p;
        int   phase_end;
        logic [BYTE_W-1:0] rnd;

        phase_send_idle  = '{0, 55, 0, 15, 0};
        phase_recv_stall = '{0, 0, 55, 15, 0};
        phase_cfg[0] = '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                         trail_first: TRAIL_FIRST_RST, trail_second: TRAIL_SECOND_RST};
        phase_cfg[1] = '{sync_first: 8'h00, sync_second: 8'hFF,
                         trail_first: 8'hFF, trail_second: 8'h00};
        // first trailer of 5 allows a frame whose length byte is its own trailer
        phase_cfg[2] = '{sync_first: 8'hFF, sync_second: 8'h00,
                         trail_first: 8'h05, trail_second: 8'hFF};
        phase_cfg[3] = '{sync_first: BYTE_W'($urandom_range(255)),
                         sync_second: BYTE_W'($urandom_range(255)),
                         trail_first: BYTE_W'($urandom_range(255)),
                         trail_second: BYTE_W'($urandom_range(255))};
        // both sync bytes equal, both trailer bytes equal
        rnd = BYTE_W'($urandom_range(255));
        phase_cfg[4] = '{sync_first: rnd, sync_second: rnd,
                         trail_first: ~rnd, trail_second: ~rnd};
        cur_cfg = phase_cfg[0];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset register values
        send_item(1'b1, 8'hFF);                     // release with nothing held
        send_item(1'b0, 8'h00);                     // ignored while hunting
        send_item(1'b0, cur_cfg.sync_first);
        send_item(1'b0, cur_cfg.sync_first);        // repeated first sync restarts
        send_item(1'b0, cur_cfg.sync_second);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'd6);
        send_item(1'b0, cur_cfg.trail_first);
        send_item(1'b0, cur_cfg.trail_second);      // completes, block now held
        send_item(1'b0, cur_cfg.sync_first);        // dropped while held
        send_item(1'b1, 8'h00);                     // release
        send_item(1'b0, cur_cfg.sync_first);
        send_item(1'b0, 8'h00);                     // broken header aborts
        send_item(1'b0, cur_cfg.sync_first);
        send_item(1'b0, cur_cfg.sync_second);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'd7);
        send_item(1'b0, 8'h12);
        send_item(1'b0, 8'hFF);                     // wrong first trailer
        send_item(1'b0, cur_cfg.sync_first);
        send_item(1'b0, cur_cfg.sync_second);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'd6);
        send_item(1'b0, cur_cfg.trail_first);
        send_item(1'b0, 8'hFF);                     // wrong second trailer

        // random part, one register setting and idle pattern per phase
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                set_config(phase_cfg[p]);
            end
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            if (cur_cfg.trail_first == 8'd5) begin
                send_frame(5, 5, FRAME_OK);
                send_item(1'b1, 8'h00);
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                run_sequence();
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes and releases under %0d register settings,",
                 bytes_sent, NUM_PHASES);
        $display("with and without stalls on both sides: %0d frames completed, %0d aborted",
                 done_count, abort_count);
        if (fail_count == 0 && pending == 0)
            $display("sync_length_crlf_frame_receiver_tb passed");
        else
            $display("sync_length_crlf_frame_receiver_tb failed");
        $finish;
    end

endmodule

// ----- sync_length_crlf_frame_receiver.f -----
sv/slcfr_pkg.sv
sv/slcfr_cfg.sv
sv/slcfr_step.sv
sv/slcfr_out.sv
sv/sync_length_crlf_frame_receiver.sv
verif/slcfr_result_checker.sv
verif/sync_length_crlf_frame_receiver_tb.sv
